/* design/tkst_pkg.sv */
// ----------------------------------------------------------------------------
// tkst_pkg
// shared constants and controller/datapath interface types for the top-k
// score table
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

   // fixed score field
   localparam int unsigned SCORE_W   = 20;
   localparam logic [SCORE_W-1:0] SCORE_MAX = 20'd999999;

   // default table shape
   localparam int unsigned DEF_TABLE_ENTRIES = 10;
   localparam int unsigned DEF_NAME_CHARS    = 6;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture offered item
      logic compare;   // compare candidate against every slot
      logic insert;    // shift the table and drop the candidate in
      logic advance;   // result taken, rotate table to next slot
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_slot; // head of table is the final slot
   } status_type;

endpackage

`default_nettype wire

/* design/tkst_ctrl.sv */
// ----------------------------------------------------------------------------
// tkst_ctrl
// sequencer: accept an item, compare, insert, then stream out every slot
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output tkst_pkg::cmd_type         cmd,
   input  wire tkst_pkg::status_type status
);
   import tkst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_INS,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;

   logic      req_fire;
   logic      rsp_fire;

   assign req_fire = req_tvalid & req_tready_ff;
   assign rsp_fire = rsp_tvalid_ff & rsp_tready;

   // commands to the datapath
   always_comb begin
      cmd         = '0;
      cmd.load    = req_fire;
      cmd.compare = (state_ff == ST_CMP);
      cmd.insert  = (state_ff == ST_INS);
      cmd.advance = rsp_fire;
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff      <= ST_CMP;
                  req_tready_ff <= 1'b0;
               end
            end
            ST_CMP: begin
               state_ff <= ST_INS;
            end
            ST_INS: begin
               state_ff      <= ST_EMIT;
               rsp_tvalid_ff <= 1'b1;
            end
            ST_EMIT: begin
               if (rsp_fire && status.last_slot) begin
                  state_ff      <= ST_IDLE;
                  rsp_tvalid_ff <= 1'b0;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= ST_IDLE;
               rsp_tvalid_ff <= 1'b0;
               req_tready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

/* design/tkst_dp.sv */
// ----------------------------------------------------------------------------
// tkst_dp
// score table cells, candidate register, slot compare, shift insert and
// rotating readout with running competition rank
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_dp #(
   parameter  int unsigned TABLE_ENTRIES = tkst_pkg::DEF_TABLE_ENTRIES,
   parameter  int unsigned NAME_CHARS    = tkst_pkg::DEF_NAME_CHARS,
   localparam int unsigned NAME_W        = 8 * NAME_CHARS,
   localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tkst_pkg::cmd_type           cmd,
   output tkst_pkg::status_type             status,
   input  wire logic [tkst_pkg::SCORE_W-1:0] in_score,
   input  wire logic [NAME_W-1:0]           in_name,
   output logic [SLOT_W-1:0]                out_slot,
   output logic [tkst_pkg::SCORE_W-1:0]     out_score,
   output logic [SLOT_W-1:0]                out_rank,
   output logic [NAME_W-1:0]                out_name,
   output logic [SLOT_W-1:0]                out_entered,
   output logic                             out_last
);
   import tkst_pkg::*;

   // table cells, slot 0 at the head
   logic [SCORE_W-1:0] score_ff [TABLE_ENTRIES];
   logic [NAME_W-1:0]  name_ff  [TABLE_ENTRIES];

   // candidate and compare results
   logic [SCORE_W-1:0]       cand_score_ff;
   logic [NAME_W-1:0]        cand_name_ff;
   logic [TABLE_ENTRIES-1:0] le_ff;
   logic [SLOT_W-1:0]        entered_ff;

   // readout position and rank of the head
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] rank_ff;

   logic [SCORE_W-1:0]       sat_score;
   logic [NAME_W-1:0]        clean_name;
   logic [TABLE_ENTRIES-1:0] le;
   logic [TABLE_ENTRIES-1:0] hit;
   logic [SLOT_W-1:0]        entered_in;

   // saturate the offered score
   assign sat_score = (in_score > SCORE_MAX) ? SCORE_MAX : in_score;

   // name ends at its first zero byte, counted from the top byte
   always_comb begin
      logic alive;
      alive      = 1'b1;
      clean_name = '0;
      for (int k = NAME_CHARS - 1; k >= 0; k--) begin
         if (in_name[k*8 +: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            clean_name[k*8 +: 8] = in_name[k*8 +: 8];
         end
      end
   end

   // per-slot compare; table is sorted so le is a thermometer code
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         le[i] = (score_ff[i] <= cand_score_ff);
      end
      hit[0] = le[0];
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
         hit[i] = le[i] & ~le[i-1];
      end
   end

   // one-hot to slot number, table size when dropped
   always_comb begin
      entered_in = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit[i]) begin
            entered_in = entered_in | SLOT_W'(i);
         end
      end
      if (hit == '0) begin
         entered_in = SLOT_W'(TABLE_ENTRIES);
      end
   end

   // candidate capture and compare registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cand_score_ff <= sat_score;
         cand_name_ff  <= clean_name;
      end
      if (cmd.compare) begin
         le_ff      <= le;
         entered_ff <= entered_in;
      end
   end

   // table cells: shift insert, or rotate one place per taken result
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            score_ff[i] <= '0;
            name_ff[i]  <= '0;
         end
      end else if (cmd.insert) begin
         if (le_ff[0]) begin
            score_ff[0] <= cand_score_ff;
            name_ff[0]  <= cand_name_ff;
         end
         for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (le_ff[i-1]) begin
               score_ff[i] <= score_ff[i-1];
               name_ff[i]  <= name_ff[i-1];
            end else if (le_ff[i]) begin
               score_ff[i] <= cand_score_ff;
               name_ff[i]  <= cand_name_ff;
            end
         end
      end else if (cmd.advance) begin
         for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
            score_ff[i] <= score_ff[i+1];
            name_ff[i]  <= name_ff[i+1];
         end
         score_ff[TABLE_ENTRIES-1] <= score_ff[0];
         name_ff[TABLE_ENTRIES-1]  <= name_ff[0];
      end
   end

   // slot counter and running rank: a tie keeps the rank of the slot above
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         rank_ff <= SLOT_W'(1);
      end else if (cmd.insert) begin
         slot_ff <= '0;
         rank_ff <= SLOT_W'(1);
      end else if (cmd.advance) begin
         slot_ff <= slot_ff + SLOT_W'(1);
         if (score_ff[1] != score_ff[0]) begin
            rank_ff <= slot_ff + SLOT_W'(2);
         end
      end
   end

   assign out_slot         = slot_ff;
   assign out_score        = score_ff[0];
   assign out_rank         = rank_ff;
   assign out_name         = name_ff[0];
   assign out_entered      = entered_ff;
   assign out_last         = (slot_ff == SLOT_W'(TABLE_ENTRIES - 1));
   assign status.last_slot = out_last;

endmodule

`default_nettype wire

/* design/top_k_score_table_insert.sv */
// ----------------------------------------------------------------------------
// top_k_score_table_insert
// sequence: first result valid once the item has passed the compare and insert steps
// items: no new item is accepted until every table slot has been read out
//   and the result of the final slot has been taken
// reset: synchronous, clears every slot to score zero and an empty name
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_table_insert #(
   parameter  int unsigned TABLE_ENTRIES = tkst_pkg::DEF_TABLE_ENTRIES,
   parameter  int unsigned NAME_CHARS    = tkst_pkg::DEF_NAME_CHARS,
   localparam int unsigned NAME_W        = 8 * NAME_CHARS,
   localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES + 1),
   localparam int unsigned REQ_W         = ((tkst_pkg::SCORE_W + NAME_W + 7) / 8) * 8,
   localparam int unsigned RSP_W         =
      ((3 * SLOT_W + tkst_pkg::SCORE_W + NAME_W + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // req_tdata: new_score, new_name, zero pad
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // rsp_tdata: slot, slot_score, slot_rank, slot_name, entered_at, zero pad
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast
);
   import tkst_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [SLOT_W-1:0]  out_slot;
   logic [SCORE_W-1:0] out_score;
   logic [SLOT_W-1:0]  out_rank;
   logic [NAME_W-1:0]  out_name;
   logic [SLOT_W-1:0]  out_entered;

   tkst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tkst_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NAME_CHARS    (NAME_CHARS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_score    (req_tdata[SCORE_W-1:0]),
      .in_name     (req_tdata[SCORE_W +: NAME_W]),
      .out_slot    (out_slot),
      .out_score   (out_score),
      .out_rank    (out_rank),
      .out_name    (out_name),
      .out_entered (out_entered),
      .out_last    (rsp_tlast)
   );

   // pack result fields, lowest first
   assign rsp_tdata = RSP_W'({out_entered, out_name, out_rank, out_score, out_slot});

   // no new item while results are still pending
   a_no_accept_while_emitting: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !rsp_tvalid
   ) else $error("item accepted while results pending");

   // first result appears after accept, once the compare and insert steps are done
   a_first_result_timing: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##3 rsp_tvalid
   ) else $error("first result late");

   // first result is slot zero with rank one
   a_first_result_head: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##3 (out_slot == '0 && out_rank == SLOT_W'(1))
   ) else $error("first result not the table head");

   // after the final slot is taken the block returns to accepting items
   a_last_returns_idle: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready)
   ) else $error("block did not return to idle after final slot");

endmodule

`default_nettype wire

/* verif/top_k_score_table_insert_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_table_insert_tb
// Offers scores and names to the ten-entry high score table and checks every
// readout item: slot, score, competition rank, name, entry slot and tlast.
// Expectations come from a behavioral copy of the table kept in a scoreboard.
// A directed opening covers saturation, ties, drops and truncated names;
// after it, random offers are aimed at the current table contents. Random
// gaps are put on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_table_insert_tb;
   import tkst_pkg::*;

   localparam int unsigned ENTRIES    = 10;
   localparam int unsigned NAME_CHARS = 6;
   localparam int unsigned NAME_W     = 8 * NAME_CHARS;
   localparam int unsigned REQ_W      = 72;
   localparam int unsigned RSP_W      = 80;
   localparam int unsigned RANDOM_OFFERS = 280;

   // response item field offsets, lowest bit up
   localparam int unsigned SLOT_LSB  = 0;
   localparam int unsigned SCORE_LSB = 4;
   localparam int unsigned RANK_LSB  = 24;
   localparam int unsigned NAME_LSB  = 28;
   localparam int unsigned ENTER_LSB = 76;

   typedef struct {
      logic [3:0]         slot;
      logic [SCORE_W-1:0] score;
      logic [3:0]         rank;
      logic [NAME_W-1:0]  name;
      logic [3:0]         entered_at;
      logic               last;
   } readout_type;

   // mirror of the score table and the readout items it must produce
   class score_table_board;
      bit [SCORE_W-1:0] scores [ENTRIES];
      bit [NAME_W-1:0]  names [ENTRIES];
      readout_type      readout_q [$];
      int unsigned      errors;

      function new();
         foreach (scores[i]) begin
            scores[i] = '0;
            names[i]  = '0;
         end
         errors = 0;
      endfunction

      // a zero byte ends the name, everything below it is cleared
      function bit [NAME_W-1:0] trim_name(bit [NAME_W-1:0] raw);
         bit [NAME_W-1:0] kept;
         kept = '0;
         for (int i = NAME_CHARS - 1; i >= 0; i--) begin
            if (raw[i*8 +: 8] == 8'h00) break;
            kept[i*8 +: 8] = raw[i*8 +: 8];
         end
         return kept;
      endfunction

      // insert an accepted offer and queue the full table readout
      function void note_offer(bit [SCORE_W-1:0] raw_score, bit [NAME_W-1:0] raw_name);
         bit [SCORE_W-1:0] score;
         int unsigned      pos;
         int unsigned      rank;
         readout_type      r;
         score = (raw_score > SCORE_MAX) ? SCORE_MAX : raw_score;
         pos = ENTRIES;
         for (int i = 0; i < ENTRIES; i++) begin
            if (scores[i] <= score) begin
               pos = i;
               break;
            end
         end
         if (pos < ENTRIES) begin
            for (int i = ENTRIES - 1; i > pos; i--) begin
               scores[i] = scores[i-1];
               names[i]  = names[i-1];
            end
            scores[pos] = score;
            names[pos]  = trim_name(raw_name);
         end
         for (int i = 0; i < ENTRIES; i++) begin
            rank = 1;
            for (int j = 0; j < ENTRIES; j++)
               if (scores[j] > scores[i]) rank++;
            r.slot       = 4'(i);
            r.score      = scores[i];
            r.rank       = 4'(rank);
            r.name       = names[i];
            r.entered_at = 4'(pos);
            r.last       = (i == ENTRIES - 1);
            readout_q.push_back(r);
         end
      endfunction

      function void compare_field(string what, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      // check one readout item against the oldest expectation
      function void check_readout(logic [RSP_W-1:0] data, logic last_bit);
         readout_type want;
         if (readout_q.size() == 0) begin
            $display("%0t: unexpected readout item: expected none, got %h", $time, data);
            errors++;
            return;
         end
         want = readout_q.pop_front();
         compare_field("slot", want.slot, data[SLOT_LSB +: 4]);
         compare_field("slot_score", want.score, data[SCORE_LSB +: SCORE_W]);
         compare_field("slot_rank", want.rank, data[RANK_LSB +: 4]);
         compare_field("slot_name", want.name, data[NAME_LSB +: NAME_W]);
         compare_field("entered_at", want.entered_at, data[ENTER_LSB +: 4]);
         compare_field("tlast", want.last, last_bit);
      endfunction

      function int unsigned pending();
         return readout_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // new_score, new_name, zero pad
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // slot, slot_score, slot_rank, slot_name, entered_at
   logic             rsp_tlast;

   score_table_board sb;
   bit               steady = 1'b0;
   int unsigned      stall_left = 0;

   top_k_score_table_insert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("top_k_score_table_insert_tb failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // response side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady && !reset && $urandom_range(0, 3) == 0) begin
         stall_left <= gap_len();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // readout monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_readout(rsp_tdata, rsp_tlast);
   end

   // offer one item and wait for it to be taken
   task automatic send_offer(bit [SCORE_W-1:0] score, bit [NAME_W-1:0] name);
      int unsigned gap;
      req_tdata  <= {{(REQ_W - SCORE_W - NAME_W){1'b0}}, name, score};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_offer(score, name);
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic bit [NAME_W-1:0] random_name();
      bit [NAME_W-1:0] n;
      n = NAME_W'({$urandom(), $urandom()});
      if ($urandom_range(0, 3) == 0) n[8*$urandom_range(0, NAME_CHARS-1) +: 8] = 8'h00;
      return n;
   endfunction

   // scores aimed at the current table: ties, neighbors, gaps and drops
   function automatic bit [SCORE_W-1:0] random_score();
      bit [SCORE_W-1:0] v;
      int unsigned      k;
      case ($urandom_range(0, 19))
         0, 1, 2, 3: v = SCORE_W'($urandom_range(0, 20'hFFFFF));
         4, 5, 6, 7: v = sb.scores[$urandom_range(0, ENTRIES-1)];
         8, 9: begin
            v = sb.scores[$urandom_range(0, ENTRIES-1)];
            if ($urandom_range(0, 1) && v < SCORE_MAX) v = v + SCORE_W'(1);
            else if (v > 0) v = v - SCORE_W'(1);
         end
         10, 11: v = (sb.scores[ENTRIES-1] > 0) ?
                     SCORE_W'($urandom_range(0, sb.scores[ENTRIES-1] - 1)) : '0;
         12: v = SCORE_W'($urandom_range(1000000, 20'hFFFFF));
         default: begin
            k = $urandom_range(1, ENTRIES-1);
            v = SCORE_W'($urandom_range(sb.scores[k], sb.scores[k-1]));
         end
      endcase
      return v;
   endfunction

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table ties, saturation, name truncation
      send_offer(20'd0,       48'h414C_4943_4500);
      send_offer(20'd999999,  48'h4D41_5845_4E44);
      send_offer(20'hFFFFF,   48'h5341_5455_5241);
      send_offer(20'd1000000, 48'h4F56_4552_2121);
      send_offer(20'd1,       48'h0000_0000_0000);
      send_offer(20'd500000,  48'hFFFF_FFFF_FFFF);
      send_offer(20'd500000,  48'h0041_4243_4445);
      send_offer(20'd250000,  48'h4142_0043_4445);
      send_offer(20'd750000,  48'h4142_4344_4500);
      send_offer(20'd100000,  48'h4142_4344_0046);
      send_offer(20'd50000,   48'h4100_0000_0041);
      // table now full of nonzero scores: drop, tie at bottom, tie at top
      send_offer(20'd0,       48'h4452_4F50_5045);
      send_offer(20'd1,       48'h4C41_5354_5449);
      send_offer(20'd0,       48'h5A45_524F_5A5A);
      send_offer(20'd999999,  48'h544F_5054_4945);
      send_offer(20'd500000,  48'h4D49_4454_4945);
      send_offer(20'd600000,  48'h5245_5354_0001);
      send_offer(20'd1,       48'h4C4F_5745_5354);

      // random offers, with one stretch free of gaps and stalls
      for (int n = 0; n < RANDOM_OFFERS; n++) begin
         steady = (n >= 120 && n < 160);
         send_offer(random_score(), random_name());
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then allow for any stray readout
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("top_k_score_table_insert_tb passed");
      end else begin
         $display("top_k_score_table_insert_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
